FILE: rtl/fds_pkg.sv
// Package for the data stack: sizes, command and error codes, transaction types.
package fds_pkg;

  // Stack capacity and derived widths
  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int NEED_W      = (CNT_W > 5) ? CNT_W : 5;

  // Command codes
  localparam logic [3:0] CMD_PUSH = 4'd0;
  localparam logic [3:0] CMD_POP  = 4'd1;
  localparam logic [3:0] CMD_DROP = 4'd2;
  localparam logic [3:0] CMD_SWAP = 4'd3;
  localparam logic [3:0] CMD_DUP  = 4'd4;
  localparam logic [3:0] CMD_ROT  = 4'd5;
  localparam logic [3:0] CMD_OVER = 4'd6;
  localparam logic [3:0] CMD_TUCK = 4'd7;
  localparam logic [3:0] CMD_PICK = 4'd8;
  localparam logic [3:0] CMD_ROLL = 4'd9;

  // Error codes
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_OVER  = 2'd1;
  localparam logic [1:0] ERR_UNDER = 2'd2;

  typedef logic signed [31:0] word_t;
  typedef logic [STACK_DEPTH-1:0][31:0] stack_t;
  typedef logic [CNT_W-1:0] count_t;

  typedef struct packed {
    logic [3:0] command;
    word_t      value;
    logic [3:0] index;
  } cmd_t;

  typedef struct packed {
    word_t      top_value;
    logic [4:0] item_count;
    logic [1:0] error;
  } res_t;

endpackage

FILE: rtl/fds_cmd_if.sv
// Command channel: valid/ready handshake carrying one stack command.
interface fds_cmd_if;
  import fds_pkg::*;

  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/fds_res_if.sv
// Result channel: valid/ready handshake carrying one stack result.
interface fds_res_if;
  import fds_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/fds_next.sv
// Next-state logic of the stack: error checks, parallel cell shifts, result.
module fds_next (
  input  fds_pkg::cmd_t   item,
  input  fds_pkg::stack_t cells,
  input  fds_pkg::count_t count,
  output fds_pkg::stack_t cells_next,
  output fds_pkg::count_t count_next,
  output fds_pkg::res_t   result
);
  import fds_pkg::*;

  logic [NEED_W-1:0] need;
  logic [NEED_W-1:0] count_x;
  logic              grows;
  logic              shrinks;
  logic              known;
  logic              under;
  logic              over;
  logic              do_op;
  logic [31:0]       sel;
  logic [31:0]       ins_val;
  stack_t            shifted_in;
  stack_t            shifted_up;

  // Command decode: cells needed and whether the stack grows or shrinks
  always_comb begin
    need    = '0;
    grows   = 1'b0;
    shrinks = 1'b0;
    known   = 1'b1;
    case (item.command)
      CMD_PUSH: begin
        grows = 1'b1;
      end
      CMD_POP, CMD_DROP: begin
        need    = NEED_W'(1);
        shrinks = 1'b1;
      end
      CMD_SWAP: need = NEED_W'(2);
      CMD_DUP: begin
        need  = NEED_W'(1);
        grows = 1'b1;
      end
      CMD_ROT: need = NEED_W'(3);
      CMD_OVER, CMD_TUCK: begin
        need  = NEED_W'(2);
        grows = 1'b1;
      end
      CMD_PICK: begin
        need  = NEED_W'(item.index) + NEED_W'(1);
        grows = 1'b1;
      end
      CMD_ROLL: need = NEED_W'(item.index) + NEED_W'(1);
      default: known = 1'b0;
    endcase
  end

  // Underflow takes priority over overflow
  assign count_x = NEED_W'(count);
  assign under   = known && (count_x < need);
  assign over    = known && !under && grows && (count == CNT_W'(STACK_DEPTH));
  assign do_op   = known && !under && !over;

  // Cell picked by index (pick, roll)
  always_comb begin
    sel = cells[0];
    for (int i = 0; i < STACK_DEPTH; i++) begin
      if (int'(item.index) == i) sel = cells[i];
    end
  end

  // Value placed on top by the growing commands
  always_comb begin
    case (item.command)
      CMD_PUSH: ins_val = item.value;
      CMD_DUP:  ins_val = cells[0];
      CMD_OVER: ins_val = cells[1];
      CMD_PICK: ins_val = sel;
      default:  ins_val = cells[0];
    endcase
  end

  // Neighbor views: every cell one place deeper, or one place shallower
  always_comb begin
    for (int i = 0; i < STACK_DEPTH; i++) begin
      shifted_in[i] = (i == 0) ? ins_val : cells[(i == 0) ? 0 : i - 1];
      shifted_up[i] = (i == STACK_DEPTH - 1) ? cells[i] :
                      cells[(i == STACK_DEPTH - 1) ? i : i + 1];
    end
  end

  // New cell contents
  always_comb begin
    cells_next = cells;
    if (do_op) begin
      case (item.command)
        CMD_PUSH, CMD_DUP, CMD_OVER, CMD_PICK: cells_next = shifted_in;
        CMD_POP, CMD_DROP: cells_next = shifted_up;
        CMD_SWAP: begin
          cells_next[0] = cells[1];
          cells_next[1] = cells[0];
        end
        CMD_ROT: begin
          cells_next[0] = cells[2];
          cells_next[1] = cells[0];
          cells_next[2] = cells[1];
        end
        CMD_TUCK: begin
          cells_next    = shifted_in;
          cells_next[0] = cells[0];
          cells_next[1] = cells[1];
          cells_next[2] = cells[0];
        end
        CMD_ROLL: begin
          cells_next[0] = sel;
          for (int i = 1; i < STACK_DEPTH; i++) begin
            if (i <= int'(item.index)) cells_next[i] = cells[i-1];
          end
        end
        default: cells_next = cells;
      endcase
    end
  end

  // Depth update
  always_comb begin
    count_next = count;
    if (do_op && grows)   count_next = count + CNT_W'(1);
    if (do_op && shrinks) count_next = count - CNT_W'(1);
  end

  // Result: popped value for pop, else the new top (zero when empty)
  always_comb begin
    if (do_op && item.command == CMD_POP) begin
      result.top_value = cells[0];
    end else if (count_next != '0) begin
      result.top_value = cells_next[0];
    end else begin
      result.top_value = '0;
    end
    result.item_count = 5'(count_next);
    if (under) begin
      result.error = ERR_UNDER;
    end else if (over) begin
      result.error = ERR_OVER;
    end else begin
      result.error = ERR_OK;
    end
  end

endmodule

FILE: rtl/forth_data_stack_unit.sv
// Forth-style data stack: cells in flip-flops, one command per cycle.
// The result of an accepted command is captured in the output register on the edge that takes the command.
// Throughput: one command per cycle; the whole cell file shifts in parallel, and
// the output register stalls the command side only while a result waits.
// Reset: synchronous rst clears the depth and the output valid; cell contents
// are left as they are and are never read above the depth.
module forth_data_stack_unit (
  input logic      clk,
  input logic      rst,
  fds_cmd_if.sink  cmd,
  fds_res_if.source res
);
  import fds_pkg::*;

  stack_t cells;
  stack_t cells_next;
  count_t count;
  count_t count_next;
  res_t   result;
  res_t   res_data;
  logic   res_valid;
  logic   accept;

  // Handshake: take a command whenever the output register is free or draining
  assign cmd.ready = !res_valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign res.valid = res_valid;
  assign res.data  = res_data;

  fds_next u_next (
    .item       (cmd.data),
    .cells      (cells),
    .count      (count),
    .cells_next (cells_next),
    .count_next (count_next),
    .result     (result)
  );

  // Cell file, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      cells <= cells_next;
    end
  end

  // Depth and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_data <= result;
    end
  end

  // Depth never exceeds capacity
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  // A failed command leaves the depth alone
  a_err_keeps_depth: assert property (@(posedge clk) disable iff (rst)
    accept && result.error != ERR_OK |=> count == $past(count))
    else $error("depth changed on an error");

  // Pop on an empty stack reports underflow
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.data.command == CMD_POP && count == '0 |=>
      res_valid && res_data.error == ERR_UNDER)
    else $error("pop on empty stack did not underflow");

  // Result count matches the registered depth
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    accept |=> res_data.item_count == 5'(count))
    else $error("result depth differs from stack depth");

endmodule
